// ===== hw/rtl/pmpc_pkg.sv =====
// Package for the PS/2 mouse packet cursor block: packet word, config bus,
// bit positions of the packet flag byte and register map. No dependencies.
`default_nettype none

package pmpc_pkg;

	// flag byte (packet byte 0) bit positions
	localparam int unsigned SyncBit  = 3;
	localparam int unsigned XSignBit = 4;
	localparam int unsigned YSignBit = 5;
	localparam int unsigned XOvfBit  = 6;
	localparam int unsigned YOvfBit  = 7;
	localparam int unsigned BtnLBit  = 0;
	localparam int unsigned BtnRBit  = 1;
	localparam int unsigned BtnMBit  = 2;

	// framing position of the next byte
	localparam logic [1:0] IDX_FIRST  = 2'd0;
	localparam logic [1:0] IDX_SECOND = 2'd1;
	localparam logic [1:0] IDX_THIRD  = 2'd2;

	// register map (byte address 4*index)
	localparam int unsigned PaddrW = 3;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [15:0] WIDTH_RST  = 16'd1024;
	localparam logic [15:0] HEIGHT_RST = 16'd768;

	// packet queue
	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		logic [7:0] flags;
		logic [7:0] dx_byte;
		logic [7:0] dy_byte;
	} packet_t;

	// screen size and re-centre request, front end of the register file
	typedef struct packed {
		logic        recentre;
		logic [15:0] width;
		logic [15:0] height;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pmpc_if.sv =====
// Channel interfaces of the PS/2 mouse packet cursor block: the input byte
// channel and the cursor word channel. No dependencies.
`default_nettype none

interface pmpc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       from_aux;

	modport source (output valid, output data_byte, output from_aux, input ready);
	modport sink (input valid, input data_byte, input from_aux, output ready);
endinterface

interface pmpc_cursor_if;
	logic        valid;
	logic        ready;
	logic [15:0] cursor_x;
	logic [15:0] cursor_y;
	logic        button_left;
	logic        button_right;
	logic        button_middle;

	modport source (output valid, output cursor_x, output cursor_y, output button_left,
		output button_right, output button_middle, input ready);
	modport sink (input valid, input cursor_x, input cursor_y, input button_left,
		input button_right, input button_middle, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pmpc_front.sv =====
// Packet framer: takes bytes, drops keyboard bytes, resyncs on the sync bit,
// and pushes complete non-overflow packets. Depends on pmpc_pkg, pmpc_if.
`default_nettype none

module pmpc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	pmpc_byte_if.sink             in_ch,
	input  wire logic             q_full,
	output pmpc_pkg::packet_t     push_data,
	output logic                  push
);

	logic [1:0] byte_idx_q;
	logic [7:0] store0_q;
	logic [7:0] store1_q;
	logic       take;

	assign in_ch.ready = !q_full;
	assign take = in_ch.valid && in_ch.ready && in_ch.from_aux;

	// third byte completes the packet; overflow packets are dropped here
	assign push = take && (byte_idx_q == pmpc_pkg::IDX_THIRD)
		&& !store0_q[pmpc_pkg::XOvfBit] && !store0_q[pmpc_pkg::YOvfBit];
	assign push_data = '{flags: store0_q, dx_byte: store1_q, dy_byte: in_ch.data_byte};

	// framing index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= pmpc_pkg::IDX_FIRST;
		end else if (take) begin
			case (byte_idx_q)
				pmpc_pkg::IDX_SECOND: byte_idx_q <= pmpc_pkg::IDX_THIRD;
				pmpc_pkg::IDX_THIRD:  byte_idx_q <= pmpc_pkg::IDX_FIRST;
				default: begin
					if (in_ch.data_byte[pmpc_pkg::SyncBit]) begin
						byte_idx_q <= pmpc_pkg::IDX_SECOND;
					end
				end
			endcase
		end
	end

	// packet byte store
	always_ff @(posedge clk) begin
		if (take) begin
			case (byte_idx_q)
				pmpc_pkg::IDX_SECOND: store1_q <= in_ch.data_byte;
				pmpc_pkg::IDX_THIRD:  store1_q <= store1_q;
				default: begin
					if (in_ch.data_byte[pmpc_pkg::SyncBit]) begin
						store0_q <= in_ch.data_byte;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pmpc_queue.sv =====
// Short packet queue between framer and cursor unit.
// Depends on pmpc_pkg.
`default_nettype none

module pmpc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire pmpc_pkg::packet_t push_data,
	input  wire logic              pop,
	output pmpc_pkg::packet_t      pop_data,
	output logic                   full,
	output logic                   empty
);

	pmpc_pkg::packet_t                  mem_q [pmpc_pkg::QDepth];
	logic [pmpc_pkg::QPtrW-1:0]         wr_ptr_q;
	logic [pmpc_pkg::QPtrW-1:0]         rd_ptr_q;
	logic [pmpc_pkg::QCntW-1:0]         cnt_q;

	assign full     = (cnt_q == pmpc_pkg::QCntW'(pmpc_pkg::QDepth));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pmpc_back.sv =====
// Cursor unit: applies a packet to the position, clamps to the screen and
// holds the cursor word in an output register. Depends on pmpc_pkg, pmpc_if.
`default_nettype none

module pmpc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pmpc_pkg::cfg_t    cfg,
	input  wire pmpc_pkg::packet_t pkt,
	input  wire logic              q_empty,
	output logic                   pop,
	pmpc_cursor_if.source          out_ch
);

	logic [31:0] pos_x_q;
	logic [31:0] pos_y_q;
	logic        out_valid_q;
	logic [15:0] out_x_q;
	logic [15:0] out_y_q;
	logic [2:0]  out_btn_q;

	logic [31:0] dx;
	logic [31:0] dy;
	logic [31:0] sum_x;
	logic [31:0] sum_y;
	logic [31:0] clamp_x;
	logic [31:0] clamp_y;
	logic        emit;

	assign pop = !q_empty && (!out_valid_q || out_ch.ready);

	// 9-bit signed deltas, sign taken from the flag byte
	assign dx = {{24{pkt.flags[pmpc_pkg::XSignBit]}}, pkt.dx_byte};
	assign dy = {{24{pkt.flags[pmpc_pkg::YSignBit]}}, pkt.dy_byte};
	assign sum_x = pos_x_q + dx;
	assign sum_y = pos_y_q - dy;

	// clamp: negative to zero, at or past the edge to size-1
	always_comb begin
		if (sum_x[31]) begin
			clamp_x = '0;
		end else if (sum_x >= {16'd0, cfg.width}) begin
			clamp_x = {16'd0, cfg.width - 16'd1};
		end else begin
			clamp_x = sum_x;
		end
		if (sum_y[31]) begin
			clamp_y = '0;
		end else if (sum_y >= {16'd0, cfg.height}) begin
			clamp_y = {16'd0, cfg.height - 16'd1};
		end else begin
			clamp_y = sum_y;
		end
	end

	assign emit = (cfg.width != '0) && (cfg.height != '0);

	// position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= {17'd0, pmpc_pkg::WIDTH_RST[15:1]};
			pos_y_q     <= {17'd0, pmpc_pkg::HEIGHT_RST[15:1]};
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.recentre) begin
				pos_x_q <= {17'd0, cfg.width[15:1]};
				pos_y_q <= {17'd0, cfg.height[15:1]};
			end else if (pop) begin
				pos_x_q <= emit ? clamp_x : sum_x;
				pos_y_q <= emit ? clamp_y : sum_y;
			end
			if (pop) begin
				out_valid_q <= emit;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// cursor word
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_x_q   <= clamp_x[15:0];
			out_y_q   <= clamp_y[15:0];
			out_btn_q <= pkt.flags[2:0];
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.cursor_x      = out_x_q;
	assign out_ch.cursor_y      = out_y_q;
	assign out_ch.button_left   = out_btn_q[pmpc_pkg::BtnLBit];
	assign out_ch.button_right  = out_btn_q[pmpc_pkg::BtnRBit];
	assign out_ch.button_middle = out_btn_q[pmpc_pkg::BtnMBit];

endmodule

`default_nettype wire

// ===== hw/rtl/ps2_mouse_packet_cursor_top.sv =====
// Top level of the PS/2 mouse packet cursor block: register file and the
// framer, queue and cursor unit. Depends on pmpc_pkg, pmpc_if and submodules.
//
//   channel   dir  word
//   in_ch     in   data_byte[7:0], from_aux
//   out_ch    out  cursor_x[15:0], cursor_y[15:0], button_left/right/middle
//   apb       in   screen_width @0x0, screen_height @0x4
//
// One byte accepted per cycle while the queue is not full. The framer pushes a
// packet on its third byte; the cursor unit pops it when the output register is
// free or being read, and the cursor word is valid in the cycle after the pop. A two-entry queue
// and the output register decouple the sides, so a stalled output fills the
// queue before in_ch.ready drops. Reset clears framing, queue and output
// valid and centres the cursor on a 1024x768 screen.
`default_nettype none

module ps2_mouse_packet_cursor_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	pmpc_byte_if.sink                         in_ch,
	pmpc_cursor_if.source                     out_ch,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pmpc_pkg::PaddrW-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [15:0]        width_q;
	logic [15:0]        height_q;
	logic               wr_en;
	pmpc_pkg::cfg_t     cfg;
	pmpc_pkg::packet_t  push_data;
	pmpc_pkg::packet_t  pop_data;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pmpc_pkg::WIDTH_RST;
			height_q <= pmpc_pkg::HEIGHT_RST;
		end else if (wr_en) begin
			case (paddr[2])
				pmpc_pkg::REG_WIDTH:  width_q  <= pwdata[15:0];
				pmpc_pkg::REG_HEIGHT: height_q <= pwdata[15:0];
				default: width_q <= width_q;
			endcase
		end
	end

	// read-back
	always_comb begin
		case (paddr[2])
			pmpc_pkg::REG_WIDTH:  prdata = {16'd0, width_q};
			pmpc_pkg::REG_HEIGHT: prdata = {16'd0, height_q};
			default: prdata = '0;
		endcase
	end

	// sizes seen by the cursor unit, with a write's value forwarded for re-centring
	always_comb begin
		cfg.recentre = wr_en;
		cfg.width    = width_q;
		cfg.height   = height_q;
		if (wr_en && (paddr[2] == pmpc_pkg::REG_WIDTH)) begin
			cfg.width = pwdata[15:0];
		end
		if (wr_en && (paddr[2] == pmpc_pkg::REG_HEIGHT)) begin
			cfg.height = pwdata[15:0];
		end
	end

	pmpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push_data (push_data),
		.push      (push)
	);

	pmpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	pmpc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pkt     (pop_data),
		.q_empty (q_empty),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for ps2_mouse_packet_cursor_top: drives PS/2 bytes and APB screen-size
// writes, predicts cursor words and checks them in order.
// Depends on pmpc_pkg, pmpc_if and the block's RTL.
`default_nettype none

module tb;
	import pmpc_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int SettleCycles = 16;
	localparam int HoldCycles = 300;
	localparam int DirRows = 24;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic        left;
		logic        right;
		logic        middle;
	} cursor_word_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         aux;
		logic         typed;
		cursor_word_t want;
	} stim_row_t;

	localparam cursor_word_t NO_WORD = '0;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PaddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pmpc_byte_if   in_ch ();
	pmpc_cursor_if out_ch ();

	ps2_mouse_packet_cursor_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// tracked block state
	logic [15:0] scr_w;
	logic [15:0] scr_h;
	logic [31:0] cur_x;
	logic [31:0] cur_y;
	logic [1:0]  frame_pos;
	logic [7:0]  held_flags;
	logic [7:0]  held_dx;

	cursor_word_t pending_cursor[$];
	int fail_count = 0;
	int cycle_count = 0;
	int send_idle = 30;
	int recv_idle = 77;
	bit hold_req = 1'b0;

	// directed bytes; typed words are the ones obvious from the start position 512,384
	stim_row_t directed_rows [DirRows] = '{
		'{8'hFF, 1'b0, 1'b0, NO_WORD},                          // keyboard byte
		'{8'h00, 1'b1, 1'b0, NO_WORD},                          // no sync bit: dropped
		'{8'h08, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b1, '{16'd512, 16'd384, 1'b0, 1'b0, 1'b0}},
		'{8'h0F, 1'b1, 1'b0, NO_WORD},                          // all buttons
		'{8'h01, 1'b1, 1'b0, NO_WORD},
		'{8'hFF, 1'b1, 1'b1, '{16'd513, 16'd129, 1'b1, 1'b1, 1'b1}},
		'{8'h48, 1'b1, 1'b0, NO_WORD},                          // x overflow
		'{8'h7F, 1'b1, 1'b0, NO_WORD},
		'{8'h7F, 1'b1, 1'b0, NO_WORD},
		'{8'h88, 1'b1, 1'b0, NO_WORD},                          // y overflow
		'{8'h01, 1'b1, 1'b0, NO_WORD},
		'{8'h01, 1'b0, 1'b0, NO_WORD},                          // keyboard mid-packet
		'{8'h01, 1'b1, 1'b0, NO_WORD},
		'{8'h39, 1'b1, 1'b0, NO_WORD},                          // dx = dy = -256
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h39, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h39, 1'b1, 1'b0, NO_WORD},                          // x below 0, y past bottom
		'{8'h00, 1'b1, 1'b0, NO_WORD},
		'{8'h00, 1'b1, 1'b1, '{16'd0, 16'd767, 1'b1, 1'b0, 1'b0}}
	};

	function automatic logic [31:0] clamp_to_screen(input logic [31:0] p, input logic [15:0] size);
		if (p[31])
			return 32'd0;
		if (p >= {16'd0, size})
			return {16'd0, size} - 32'd1;
		return p;
	endfunction

	// framing and cursor update for one accepted byte
	task automatic advance_cursor(input logic [7:0] b, input logic aux, output bit emitted,
		output cursor_word_t w);
		logic [31:0] dx;
		logic [31:0] dy;
		emitted = 1'b0;
		w = NO_WORD;
		if (aux) begin
			if (frame_pos == IDX_FIRST || frame_pos > IDX_THIRD) begin
				if (b[SyncBit]) begin
					held_flags = b;
					frame_pos = IDX_SECOND;
				end
			end else if (frame_pos == IDX_SECOND) begin
				held_dx = b;
				frame_pos = IDX_THIRD;
			end else begin
				frame_pos = IDX_FIRST;
				if (held_flags[SyncBit] && !held_flags[XOvfBit] && !held_flags[YOvfBit]) begin
					dx = {{24{held_flags[XSignBit]}}, held_dx};
					dy = {{24{held_flags[YSignBit]}}, b};
					cur_x = cur_x + dx;
					cur_y = cur_y - dy;
					if (scr_w != 16'd0 && scr_h != 16'd0) begin
						cur_x = clamp_to_screen(cur_x, scr_w);
						cur_y = clamp_to_screen(cur_y, scr_h);
						w = '{cur_x[15:0], cur_y[15:0], held_flags[BtnLBit],
							held_flags[BtnRBit], held_flags[BtnMBit]};
						emitted = 1'b1;
					end
				end
			end
		end
	endtask

	// offer one byte, wait for the handshake, then track it
	task automatic send_byte(input logic [7:0] b, input logic aux, input logic typed,
		input cursor_word_t want);
		bit emitted;
		cursor_word_t w;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data_byte = b;
		in_ch.from_aux = aux;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		advance_cursor(b, aux, emitted, w);
		if (emitted)
			pending_cursor.push_back(typed ? want : w);
	endtask

	// mostly well-formed packets, some stray bytes and keyboard traffic
	task automatic send_random(input int n_items);
		int sent;
		int pick;
		logic [7:0] flags;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_WORD);
			end else if (pick < 16) begin
				send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_WORD);
				sent++;
			end else begin
				flags = 8'($urandom_range(0, 255));
				flags[SyncBit] = 1'b1;
				if ($urandom_range(0, 9) != 0) begin
					flags[XOvfBit] = 1'b0;
					flags[YOvfBit] = 1'b0;
				end
				send_byte(flags, 1'b1, 1'b0, NO_WORD);
				send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_WORD);
				send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_WORD);
				sent += 3;
			end
		end
	endtask

	// stop offering, wait for every expected word, then let the pipeline settle
	task automatic drain;
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_cursor.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// one APB transfer; read data is checked against value on reads
	task automatic apb_xfer(input logic is_write, input logic idx, input logic [15:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = is_write;
		paddr = {idx, 2'b00};
		pwdata = {16'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (!is_write && prdata[15:0] !== value) begin
			$error("prdata[%0d]: expected %0d, actual %0d", idx, value, prdata[15:0]);
			fail_count++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// write both sizes, read them back; each write re-centres the cursor
	task automatic set_screen(input logic [15:0] w, input logic [15:0] h);
		apb_xfer(1'b1, REG_WIDTH, w);
		scr_w = w;
		cur_x = {16'd0, scr_w} / 2;
		cur_y = {16'd0, scr_h} / 2;
		apb_xfer(1'b1, REG_HEIGHT, h);
		scr_h = h;
		cur_x = {16'd0, scr_w} / 2;
		cur_y = {16'd0, scr_h} / 2;
		apb_xfer(1'b0, REG_WIDTH, w);
		apb_xfer(1'b0, REG_HEIGHT, h);
	endtask

	// receiver: random stalls plus an occasional long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HoldCycles;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// compare each delivered word with the oldest expectation
	always @(posedge clk) begin
		cursor_word_t exp_w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_cursor.size() == 0) begin
				$error("unexpected cursor word x=%0d y=%0d", out_ch.cursor_x, out_ch.cursor_y);
				fail_count++;
			end else begin
				exp_w = pending_cursor.pop_front();
				if (out_ch.cursor_x !== exp_w.x) begin
					$error("cursor_x: expected %0d, actual %0d", exp_w.x, out_ch.cursor_x);
					fail_count++;
				end
				if (out_ch.cursor_y !== exp_w.y) begin
					$error("cursor_y: expected %0d, actual %0d", exp_w.y, out_ch.cursor_y);
					fail_count++;
				end
				if (out_ch.button_left !== exp_w.left) begin
					$error("button_left: expected %0d, actual %0d", exp_w.left,
						out_ch.button_left);
					fail_count++;
				end
				if (out_ch.button_right !== exp_w.right) begin
					$error("button_right: expected %0d, actual %0d", exp_w.right,
						out_ch.button_right);
					fail_count++;
				end
				if (out_ch.button_middle !== exp_w.middle) begin
					$error("button_middle: expected %0d, actual %0d", exp_w.middle,
						out_ch.button_middle);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.from_aux = 1'b0;
		scr_w = WIDTH_RST;
		scr_h = HEIGHT_RST;
		cur_x = {16'd0, WIDTH_RST} / 2;
		cur_y = {16'd0, HEIGHT_RST} / 2;
		frame_pos = IDX_FIRST;
		held_flags = '0;
		held_dx = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values, then the directed table at the reset screen size
		apb_xfer(1'b0, REG_WIDTH, WIDTH_RST);
		apb_xfer(1'b0, REG_HEIGHT, HEIGHT_RST);
		for (int i = 0; i < DirRows; i++)
			send_byte(directed_rows[i].data, directed_rows[i].aux, directed_rows[i].typed,
				directed_rows[i].want);

		// sender heavy, receiver light; a long hold-off fills the block
		send_random(150);
		hold_req = 1'b1;
		send_random(60);
		drain();
		send_random(140);
		drain();

		// largest screen, sender light, receiver heavy
		send_idle = 77;
		recv_idle = 30;
		set_screen(16'hFFFF, 16'hFFFF);
		send_random(350);
		drain();

		// no idling from here on
		send_idle = 0;
		recv_idle = 0;
		set_screen(16'd1, 16'd1);
		send_random(100);
		drain();

		// zero width, then zero height: position moves, nothing emitted
		set_screen(16'd0, 16'd1);
		send_random(60);
		drain();
		set_screen(16'd5, 16'd0);
		send_random(30);
		drain();

		set_screen(16'd640, 16'd480);
		hold_req = 1'b1;
		send_random(200);
		drain();

		for (int k = 0; k < 3; k++) begin
			set_screen(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
			send_random(60);
			drain();
		end

		repeat (SettleCycles) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

// ===== ps2_mouse_packet_cursor_top.f =====
hw/rtl/pmpc_pkg.sv
hw/rtl/pmpc_if.sv
hw/rtl/pmpc_front.sv
hw/rtl/pmpc_queue.sv
hw/rtl/pmpc_back.sv
hw/rtl/ps2_mouse_packet_cursor_top.sv
bench/tb.sv
